// ===== hdl/fsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants of the fixed-split replacement engine.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int PAGE_W = 31;
    localparam int CFG_W  = 7;

    localparam logic CFG_CAPACITY  = 1'b0;
    localparam logic CFG_T1_TARGET = 1'b1;

    localparam logic [CFG_W-1:0] CAPACITY_RST  = 7'd64;
    localparam logic [CFG_W-1:0] T1_TARGET_RST = 7'd32;

    typedef enum logic [2:0] {
        L_EMPTY = 3'd0,
        L_T1    = 3'd1,
        L_T2    = 3'd2,
        L_B1    = 3'd3,
        L_B2    = 3'd4
    } t_lst;

    typedef enum logic [1:0] {
        SM_MATCH  = 2'd0,
        SM_OLDEST = 2'd1,
        SM_FREE   = 2'd2
    } t_smode;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_DETACH = 2'd1,
        OP_MOVE   = 2'd2
    } t_op;

    typedef struct packed {
        logic   load_page;
        logic   scan_start;
        t_smode scan_mode;
        t_lst   scan_list;
        t_op    op;
        t_lst   to;
        logic   wr_page;
    } t_cmd;

    typedef struct packed {
        logic scan_busy;
        logic sel_ok;
        logic sel_resident;
        logic miss_full;
        logic t1_ge_p;
        logic t1_over;
        logic t1b1_over;
        logic t2_over;
        logic t2b2_over;
    } t_sts;

endpackage

// ===== hdl/fixed_split_cache_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_split_cache_replacement
// Fixed-split (T1/T2 + ghost B1/B2) replacement policy engine.
// Each lookup, eviction or trim step is one scan of the tag store by the
//   one-entry-per-cycle tag scanner. One request is in flight at a time.
// Reset: synchronous active low; all lists empty, capacity 64, target 32.
// ----------------------------------------------------------------------------
module fixed_split_cache_replacement import fsc_pkg::*; #(
    parameter int MAX_CAPACITY  = 64,
    parameter int STORE_ENTRIES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [31:0]      i_s_tdata,   // [30:0] page_id
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,   // [0] hit, [1] ghost_hit
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic hit, ghost_hit;

    // registers change only between requests
    assign o_cfg_ready = o_s_tready;
    assign o_m_tdata   = {6'b0, ghost_hit, hit};

    fsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_hit       (hit),
        .o_ghost_hit (ghost_hit),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fsc_dpath #(
        .MAX_CAPACITY  (MAX_CAPACITY),
        .STORE_ENTRIES (STORE_ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_page      (i_s_tdata[PAGE_W-1:0]),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ===== hdl/fsc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_dpath
// Tag store, list/recency cells, list counters, config and the entry scanner.
// ----------------------------------------------------------------------------
module fsc_dpath import fsc_pkg::*; #(
    parameter int MAX_CAPACITY  = 64,
    parameter int STORE_ENTRIES = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [PAGE_W-1:0] i_page,
    input  t_cmd              i_cmd,
    output t_sts              o_sts
);

    localparam int IW   = $clog2(STORE_ENTRIES);
    localparam int KW   = $clog2(STORE_ENTRIES + 1);
    localparam int MW   = $clog2(MAX_CAPACITY + 1);
    localparam int BW   = (KW > MW) ? KW : MW;
    localparam int CMPW = ((BW > CFG_W) ? BW : CFG_W) + 2;
    localparam logic [IW-1:0] LAST = IW'(STORE_ENTRIES - 1);

    logic [CFG_W-1:0]  r_cap, r_tgt;
    logic [PAGE_W-1:0] r_page;
    logic [PAGE_W-1:0] r_page_mem [STORE_ENTRIES];
    logic [PAGE_W-1:0] r_pg_q;
    t_lst              r_list [STORE_ENTRIES];
    t_lst              n_list [STORE_ENTRIES];
    logic [IW-1:0]     r_rec  [STORE_ENTRIES];
    logic [IW-1:0]     n_rec  [STORE_ENTRIES];
    logic [KW-1:0]     r_c_t1, r_c_t2, r_c_b1, r_c_b2;
    logic [KW-1:0]     n_c_t1, n_c_t2, n_c_b1, n_c_b2;

    logic              r_busy, r_iss, r_chk;
    t_smode            r_mode;
    t_lst              r_slist;
    logic [IW-1:0]     r_idx, r_idx_d, r_sel, r_sel_rec;
    logic              r_sel_ok;
    t_lst              r_sel_list;

    logic [CMPW-1:0]   cap_e, tgt_e, c_v, p_v, t1_v, t2_v, b1_v, b2_v;
    t_lst              e_list;
    logic [IW-1:0]     e_rec;
    logic [KW-1:0]     s_cnt;
    logic              e_hit;

    function automatic logic [KW-1:0] cnt_of(input t_lst l, input logic [KW-1:0] a,
                                             input logic [KW-1:0] b, input logic [KW-1:0] x,
                                             input logic [KW-1:0] y);
        logic [KW-1:0] v;
        case (l)
            L_T1:    v = a;
            L_T2:    v = b;
            L_B1:    v = x;
            L_B2:    v = y;
            default: v = '0;
        endcase
        return v;
    endfunction

    // effective capacity and target
    always_comb begin
        cap_e = CMPW'(r_cap);
        tgt_e = CMPW'(r_tgt);
        if (cap_e == '0) begin
            c_v = CMPW'(1);
        end else if (cap_e > CMPW'(MAX_CAPACITY)) begin
            c_v = CMPW'(MAX_CAPACITY);
        end else begin
            c_v = cap_e;
        end
        p_v  = (tgt_e > c_v) ? c_v : tgt_e;
        t1_v = CMPW'(r_c_t1);
        t2_v = CMPW'(r_c_t2);
        b1_v = CMPW'(r_c_b1);
        b2_v = CMPW'(r_c_b2);
    end

    assign o_sts.scan_busy    = r_busy;
    assign o_sts.sel_ok       = r_sel_ok;
    assign o_sts.sel_resident = (r_sel_list == L_T1) || (r_sel_list == L_T2);
    assign o_sts.miss_full    = (t1_v + b1_v) >= c_v;
    assign o_sts.t1_ge_p      = t1_v >= p_v;
    assign o_sts.t1_over      = t1_v > p_v;
    assign o_sts.t1b1_over    = ((t1_v + b1_v) > c_v) && (b1_v != '0);
    assign o_sts.t2_over      = t2_v > (c_v - p_v);
    assign o_sts.t2b2_over    = ((t2_v + b2_v) > c_v) && (b2_v != '0);

    // scanner compare on the entry read in the previous cycle
    always_comb begin
        e_list = r_list[r_idx_d];
        e_rec  = r_rec[r_idx_d];
        s_cnt  = cnt_of(r_slist, r_c_t1, r_c_t2, r_c_b1, r_c_b2) - KW'(1);
        case (r_mode)
            SM_MATCH:  e_hit = (e_list != L_EMPTY) && (r_pg_q == r_page);
            SM_OLDEST: e_hit = (e_list == r_slist) && (KW'(e_rec) == s_cnt);
            SM_FREE:   e_hit = (e_list == L_EMPTY);
            default:   e_hit = 1'b0;
        endcase
    end

    // list update: detach and/or push to a head
    always_comb begin
        n_c_t1 = r_c_t1;
        n_c_t2 = r_c_t2;
        n_c_b1 = r_c_b1;
        n_c_b2 = r_c_b2;
        for (int i = 0; i < STORE_ENTRIES; i++) begin
            n_list[i] = r_list[i];
            n_rec[i]  = r_rec[i];
            if (i_cmd.op != OP_NONE) begin
                if (IW'(i) == r_sel) begin
                    if (i_cmd.op == OP_MOVE) begin
                        n_list[i] = i_cmd.to;
                        n_rec[i]  = '0;
                    end else begin
                        n_list[i] = L_EMPTY;
                    end
                end else begin
                    if (r_sel_list != L_EMPTY && r_list[i] == r_sel_list
                        && r_rec[i] > r_sel_rec) begin
                        n_rec[i] = r_rec[i] - IW'(1);
                    end
                    if (i_cmd.op == OP_MOVE && r_list[i] == i_cmd.to) begin
                        n_rec[i] = n_rec[i] + IW'(1);
                    end
                end
            end
        end
        if (i_cmd.op != OP_NONE) begin
            case (r_sel_list)
                L_T1:    n_c_t1 = n_c_t1 - KW'(1);
                L_T2:    n_c_t2 = n_c_t2 - KW'(1);
                L_B1:    n_c_b1 = n_c_b1 - KW'(1);
                L_B2:    n_c_b2 = n_c_b2 - KW'(1);
                default: ;
            endcase
        end
        if (i_cmd.op == OP_MOVE) begin
            case (i_cmd.to)
                L_T1:    n_c_t1 = n_c_t1 + KW'(1);
                L_T2:    n_c_t2 = n_c_t2 + KW'(1);
                L_B1:    n_c_b1 = n_c_b1 + KW'(1);
                L_B2:    n_c_b2 = n_c_b2 + KW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_MOVE && i_cmd.wr_page) begin
            r_page_mem[r_sel] <= r_page;
        end
        r_pg_q <= r_page_mem[r_idx];
        if (i_cmd.load_page) begin
            r_page <= i_page;
        end
        for (int i = 0; i < STORE_ENTRIES; i++) begin
            r_rec[i] <= n_rec[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAPACITY_RST;
            r_tgt  <= T1_TARGET_RST;
            r_c_t1 <= '0;
            r_c_t2 <= '0;
            r_c_b1 <= '0;
            r_c_b2 <= '0;
            for (int i = 0; i < STORE_ENTRIES; i++) begin
                r_list[i] <= L_EMPTY;
            end
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_CAPACITY) begin
                r_cap <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_T1_TARGET) begin
                r_tgt <= i_cfg_data;
            end
            r_c_t1 <= n_c_t1;
            r_c_t2 <= n_c_t2;
            r_c_b1 <= n_c_b1;
            r_c_b2 <= n_c_b2;
            for (int i = 0; i < STORE_ENTRIES; i++) begin
                r_list[i] <= n_list[i];
            end
        end
    end

    // scanner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_iss    <= 1'b0;
            r_chk    <= 1'b0;
            r_sel_ok <= 1'b0;
            r_idx    <= '0;
            r_idx_d  <= '0;
            r_sel    <= '0;
            r_mode   <= SM_MATCH;
            r_slist  <= L_EMPTY;
            r_sel_list <= L_EMPTY;
            r_sel_rec  <= '0;
        end else if (i_cmd.scan_start) begin
            r_busy   <= 1'b1;
            r_iss    <= 1'b1;
            r_chk    <= 1'b0;
            r_sel_ok <= 1'b0;
            r_idx    <= '0;
            r_mode   <= i_cmd.scan_mode;
            r_slist  <= i_cmd.scan_list;
        end else if (r_busy) begin
            if (r_chk && e_hit) begin
                r_busy     <= 1'b0;
                r_iss      <= 1'b0;
                r_chk      <= 1'b0;
                r_sel_ok   <= 1'b1;
                r_sel      <= r_idx_d;
                r_sel_list <= e_list;
                r_sel_rec  <= e_rec;
            end else begin
                if (r_iss) begin
                    r_idx_d <= r_idx;
                    r_chk   <= 1'b1;
                    if (r_idx == LAST) begin
                        r_iss <= 1'b0;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end else begin
                    r_chk <= 1'b0;
                end
                if (r_chk && r_idx_d == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    a_chk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> r_busy) else $error("scan compare outside a scan");
    a_no_op_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op != OP_NONE) |-> !r_busy) else $error("list update during scan");
    a_cnt_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMPW'(r_c_t1) + CMPW'(r_c_t2) + CMPW'(r_c_b1) + CMPW'(r_c_b2))
            <= CMPW'(STORE_ENTRIES)) else $error("list counts exceed store");

endmodule

// ===== hdl/fsc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_ctrl
// Request sequencer: lookup, miss eviction/insert, hit promotion and trims.
// ----------------------------------------------------------------------------
module fsc_ctrl import fsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output logic o_hit,
    output logic o_ghost_hit,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_LOOK = 14'b00000000000010,
        S_DROP = 14'b00000000000100,
        S_DEM  = 14'b00000000001000,
        S_FREE = 14'b00000000010000,
        S_TR1  = 14'b00000000100000,
        S_TR1W = 14'b00000001000000,
        S_TB1  = 14'b00000010000000,
        S_TB1W = 14'b00000100000000,
        S_TR2  = 14'b00001000000000,
        S_TR2W = 14'b00010000000000,
        S_TB2  = 14'b00100000000000,
        S_TB2W = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_res_hit, r_res_ghost, n_res_hit, n_res_ghost;
    logic   r_out_valid, r_out_hit, r_out_ghost;
    logic   done;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_ghost_hit = r_out_ghost;
    assign done        = !i_sts.scan_busy;

    always_comb begin
        n_state     = r_state;
        n_res_hit   = r_res_hit;
        n_res_ghost = r_res_ghost;
        o_cmd.load_page  = 1'b0;
        o_cmd.scan_start = 1'b0;
        o_cmd.scan_mode  = SM_OLDEST;
        o_cmd.scan_list  = L_EMPTY;
        o_cmd.op         = OP_NONE;
        o_cmd.to         = L_EMPTY;
        o_cmd.wr_page    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_page  = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_mode  = SM_MATCH;
                    n_state          = S_LOOK;
                end
            end
            S_LOOK: begin
                if (done) begin
                    if (i_sts.sel_ok) begin
                        o_cmd.op    = OP_MOVE;
                        o_cmd.to    = L_T2;
                        n_res_hit   = i_sts.sel_resident;
                        n_res_ghost = !i_sts.sel_resident;
                        n_state     = S_TR1;
                    end else begin
                        n_res_hit        = 1'b0;
                        n_res_ghost      = 1'b0;
                        o_cmd.scan_start = 1'b1;
                        if (i_sts.miss_full) begin
                            o_cmd.scan_list = L_B1;
                            n_state         = S_DROP;
                        end else if (i_sts.t1_ge_p) begin
                            o_cmd.scan_list = L_T1;
                            n_state         = S_DEM;
                        end else begin
                            o_cmd.scan_mode = SM_FREE;
                            n_state         = S_FREE;
                        end
                    end
                end
            end
            S_DROP: begin
                if (done) begin
                    if (i_sts.sel_ok) begin
                        o_cmd.op = OP_DETACH;
                    end
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_list  = L_T1;
                    n_state          = S_DEM;
                end
            end
            S_DEM: begin
                if (done) begin
                    if (i_sts.sel_ok) begin
                        o_cmd.op = OP_MOVE;
                        o_cmd.to = L_B1;
                    end
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_mode  = SM_FREE;
                    n_state          = S_FREE;
                end
            end
            S_FREE: begin
                if (done) begin
                    if (i_sts.sel_ok) begin
                        o_cmd.op      = OP_MOVE;
                        o_cmd.to      = L_T1;
                        o_cmd.wr_page = 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_TR1: begin
                if (i_sts.t1_over) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_list  = L_T1;
                    n_state          = S_TR1W;
                end else begin
                    n_state = S_TB1;
                end
            end
            S_TR1W: begin
                if (done) begin
                    if (i_sts.sel_ok) begin
                        o_cmd.op = OP_MOVE;
                        o_cmd.to = L_B1;
                        n_state  = S_TR1;
                    end else begin
                        n_state = S_TB1;
                    end
                end
            end
            S_TB1: begin
                if (i_sts.t1b1_over) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_list  = L_B1;
                    n_state          = S_TB1W;
                end else begin
                    n_state = S_TR2;
                end
            end
            S_TB1W: begin
                if (done) begin
                    if (i_sts.sel_ok) begin
                        o_cmd.op = OP_DETACH;
                        n_state  = S_TB1;
                    end else begin
                        n_state = S_TR2;
                    end
                end
            end
            S_TR2: begin
                if (i_sts.t2_over) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_list  = L_T2;
                    n_state          = S_TR2W;
                end else begin
                    n_state = S_TB2;
                end
            end
            S_TR2W: begin
                if (done) begin
                    if (i_sts.sel_ok) begin
                        o_cmd.op = OP_MOVE;
                        o_cmd.to = L_B2;
                        n_state  = S_TR2;
                    end else begin
                        n_state = S_TB2;
                    end
                end
            end
            S_TB2: begin
                if (i_sts.t2b2_over) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_list  = L_B2;
                    n_state          = S_TB2W;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_TB2W: begin
                if (done) begin
                    if (i_sts.sel_ok) begin
                        o_cmd.op = OP_DETACH;
                        n_state  = S_TB2;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res_hit   <= n_res_hit;
        r_res_ghost <= n_res_ghost;
        if (r_state == S_DONE && (!r_out_valid || i_m_tready)) begin
            r_out_hit   <= r_res_hit;
            r_out_ghost <= r_res_ghost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_LOOK))
        else $error("accepted beat did not start lookup");
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_ghost))
        else $error("hit and ghost hit together");
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside completion");

endmodule
